// File: src/pcx_rle_line_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// PCX RLE line decoder assertion macros
// Shared property wrappers for the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef PCX_RLE_LINE_DECODER_UNIT_MACROS_SVH
`define PCX_RLE_LINE_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PCXRLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define PCXRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pcxrle_pkg.sv
// ----------------------------------------------------------------------------
// PCX RLE line decoder package
// Widths, stream constants and configuration register indexes.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

    localparam int BYTE_W  = 8;
    localparam int LINE_W  = 18;
    localparam int COUNT_W = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] HEADER_MARK = 8'hC0;
    localparam logic [BYTE_W-1:0] COUNT_MASK  = 8'h3F;

    localparam logic [LINE_W-1:0] LINE_LEN_RESET = 18'd80;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_LENGTH = 2'd0,
        REG_RAW_MODE    = 2'd1
    } t_cfg_reg;

endpackage

// File: src/pcx_rle_line_decoder_unit.sv
// ----------------------------------------------------------------------------
// PCX RLE line decoder unit
// Decodes a PCX run-length byte stream into scan-line bytes, flagging line
// ends and the last byte produced by each input transfer.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                   Payload
//  --------  ---------  --------------------------  ----------------------------
//  input     in         i_in_valid / o_in_stall     i_data_byte
//  output    out        o_out_valid / i_out_stall   o_pixel_byte, o_end_of_line,
//                                                   o_last_of_run
//  config    in         i_cfg_we                    i_cfg_index, i_cfg_data
//
//  Literal and raw bytes: one input transfer per cycle while the output drains.
//  Run header: taken with no result.
//  Run value byte: emits N bytes (N = 1..63, clipped at line end); one shared
//  increment-and-compare on the line position runs per byte.
//  Input stalls while a run is repeating or the output register is held.
//  Reset (synchronous, active low) clears line position, run state, output
//  valid and restores line_length = 80, raw_mode = 0.
// ----------------------------------------------------------------------------
module pcx_rle_line_decoder_unit
    import pcxrle_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LINE_W-1:0]    i_cfg_data,
    // compressed input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_W-1:0]    i_data_byte,
    // decoded output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [BYTE_W-1:0]    o_pixel_byte,
    output logic                 o_end_of_line,
    output logic                 o_last_of_run
);

    // configuration registers
    logic [LINE_W-1:0]  r_line_length;
    logic               r_raw_mode;

    // decoder state
    logic [LINE_W-1:0]  r_line_pos,    n_line_pos;
    logic               r_run_pending, n_run_pending;
    logic [COUNT_W-1:0] r_run_count,   n_run_count;
    logic [COUNT_W-1:0] r_rep_left,    n_rep_left;   // bytes still to repeat
    logic [BYTE_W-1:0]  r_rep_byte;

    // output register
    logic               r_out_valid,   n_out_valid;
    logic [BYTE_W-1:0]  r_pixel_byte;
    logic               r_eol;
    logic               r_last;

    // shared emit unit
    logic               em_go;
    logic [BYTE_W-1:0]  em_byte;
    logic [COUNT_W-1:0] em_remain;
    logic               em_eol;
    logic               em_last;
    logic [LINE_W-1:0]  eff_len;
    logic [LINE_W:0]    pos_inc;

    logic               out_free;
    logic               in_xfer;
    logic               is_header;
    logic [COUNT_W-1:0] hdr_count;

    assign out_free   = !r_out_valid || !i_out_stall;
    // hold input off while a run repeats or the result slot is blocked
    assign o_in_stall = (r_rep_left != '0) || !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign is_header = (i_data_byte & HEADER_MARK) == HEADER_MARK;
    assign hdr_count = COUNT_W'(i_data_byte & COUNT_MASK);

    // A zero line length behaves as one. If the position is already at or
    // past a lowered length, the next byte ends the line, which also clips
    // any run to that single byte.
    assign eff_len = (r_line_length == '0) ? LINE_W'(1) : r_line_length;
    assign pos_inc = {1'b0, r_line_pos} + (LINE_W+1)'(1);
    assign em_eol  = pos_inc >= {1'b0, eff_len};
    assign em_last = (em_remain == COUNT_W'(1)) || em_eol;

    always_comb begin
        em_go         = 1'b0;
        em_byte       = r_rep_byte;
        em_remain     = r_rep_left;
        n_run_pending = r_run_pending;
        n_run_count   = r_run_count;

        if (r_rep_left != '0) begin
            // run in progress: one byte whenever the output slot frees
            em_go = out_free;
        end else if (in_xfer) begin
            em_byte   = i_data_byte;
            em_remain = COUNT_W'(1);
            if (r_raw_mode) begin
                // raw mode drops any pending header
                em_go         = 1'b1;
                n_run_pending = 1'b0;
            end else if (r_run_pending) begin
                em_go         = 1'b1;
                em_remain     = r_run_count;
                n_run_pending = 1'b0;
            end else if (is_header) begin
                n_run_pending = 1'b1;
                n_run_count   = (hdr_count == '0) ? COUNT_W'(1) : hdr_count;
            end else begin
                em_go = 1'b1;
            end
        end

        n_rep_left = r_rep_left;
        n_line_pos = r_line_pos;
        if (em_go) begin
            n_rep_left = em_last ? '0 : em_remain - COUNT_W'(1);
            n_line_pos = em_eol ? '0 : pos_inc[LINE_W-1:0];
        end

        n_out_valid = em_go || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= LINE_LEN_RESET;
            r_raw_mode    <= 1'b0;
            r_line_pos    <= '0;
            r_run_pending <= 1'b0;
            r_run_count   <= '0;
            r_rep_left    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_LINE_LENGTH: r_line_length <= i_cfg_data;
                    REG_RAW_MODE:    r_raw_mode    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_line_pos    <= n_line_pos;
            r_run_pending <= n_run_pending;
            r_run_count   <= n_run_count;
            r_rep_left    <= n_rep_left;
            r_out_valid   <= n_out_valid;
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (em_go) begin
            r_rep_byte   <= em_byte;
            r_pixel_byte <= em_byte;
            r_eol        <= em_eol;
            r_last       <= em_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_byte  = r_pixel_byte;
    assign o_end_of_line = r_eol;
    assign o_last_of_run = r_last;

endmodule

// File: src/pcxrle_checker.sv
// ----------------------------------------------------------------------------
// PCX RLE line decoder checker
// Port-level properties of the decoder, bound into the decoder module.
// ----------------------------------------------------------------------------
`include "pcx_rle_line_decoder_unit_macros.svh"

module pcxrle_checker
    import pcxrle_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [BYTE_W-1:0]    o_pixel_byte,
    input logic                 o_end_of_line,
    input logic                 o_last_of_run
);

    logic              out_held;
    logic              in_xfer;
    logic              out_mid_run;
    logic [BYTE_W+1:0] out_payload;

    assign out_held    = o_out_valid && i_out_stall;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_mid_run = o_out_valid && !i_out_stall && !o_last_of_run;
    assign out_payload = {o_pixel_byte, o_end_of_line, o_last_of_run};

    // a held result stays valid
    `PCXRLE_ASSERT_NEXT(a_out_valid_held, i_clk, i_rst_n, out_held, o_out_valid, "valid dropped")

    // a held result keeps its payload
    `PCXRLE_ASSERT_NEXT(a_out_payload_held, i_clk, i_rst_n, out_held, $stable(out_payload), "payload moved")

    // no input transfer while the result slot is blocked
    `PCXRLE_ASSERT_NOW(a_no_in_when_blocked, i_clk, i_rst_n, in_xfer, !out_held, "input while held")

    // a run keeps input stalled until its last byte has gone
    `PCXRLE_ASSERT_NOW(a_run_stalls_input, i_clk, i_rst_n, out_mid_run, o_in_stall, "input open mid-run")

endmodule

bind pcx_rle_line_decoder_unit pcxrle_checker u_pcxrle_checker (.*);

// File: verif/pcx_rle_line_decoder_unit_test_pkg.sv
// ----------------------------------------------------------------------------
// PCX RLE line decoder scoreboard
// Predicts the decoded scan-line bytes for each accepted input transfer and
// checks output transfers against them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package pcx_rle_line_decoder_unit_test_pkg;

    import pcxrle_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] pixel;
        logic              eol;
        logic              last;
    } t_decoded_byte;

    class pcx_line_scoreboard;

        logic [LINE_W-1:0]  line_length;
        logic               raw_mode;
        logic [LINE_W-1:0]  line_pos;
        logic               run_pending;
        logic [COUNT_W-1:0] run_count;
        t_decoded_byte      expected_pixels[$];
        int unsigned        mismatches;

        function new();
            line_length = LINE_LEN_RESET;
            raw_mode    = 1'b0;
            line_pos    = '0;
            run_pending = 1'b0;
            run_count   = '0;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LINE_W-1:0] value);
            if (idx == REG_LINE_LENGTH) begin
                line_length = value;
            end else if (idx == REG_RAW_MODE) begin
                raw_mode = value[0];
            end
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction

        // zero length behaves as one
        function int unsigned eff_length();
            return (line_length == '0) ? 1 : int'(line_length);
        endfunction

        function void put_pixel(logic [BYTE_W-1:0] value, logic last);
            int unsigned   next_pos;
            t_decoded_byte d;
            next_pos = line_pos + 1;
            d.pixel  = value;
            d.eol    = (next_pos >= eff_length());
            d.last   = last;
            expected_pixels.push_back(d);
            line_pos = d.eol ? '0 : LINE_W'(next_pos);
        endfunction

        function void take_byte(logic [BYTE_W-1:0] b);
            int unsigned n;
            int unsigned room;
            int unsigned k;
            if (raw_mode) begin
                run_pending = 1'b0;
                put_pixel(b, 1'b1);
            end else if (run_pending) begin
                n    = run_count;
                // past the end of a shortened line: one byte closes it
                room = (line_pos < eff_length()) ? eff_length() - line_pos : 1;
                if (n > room) n = room;
                if (n == 0) n = 1;
                run_pending = 1'b0;
                for (k = 0; k < n; k++) begin
                    put_pixel(b, (k + 1 == n));
                end
            end else if ((b & HEADER_MARK) == HEADER_MARK) begin
                run_count   = ((b & COUNT_MASK) == '0) ? COUNT_W'(1) : b[COUNT_W-1:0];
                run_pending = 1'b1;
            end else begin
                put_pixel(b, 1'b1);
            end
        endfunction

        function void check_pixel(logic [BYTE_W-1:0] pixel, logic eol, logic last);
            t_decoded_byte d;
            if (expected_pixels.size() == 0) begin
                $error("unexpected output transfer: pixel_byte %02h", pixel);
                mismatches++;
                return;
            end
            d = expected_pixels.pop_front();
            if (pixel !== d.pixel) begin
                $error("pixel_byte: expected %02h, got %02h", d.pixel, pixel);
                mismatches++;
            end
            if (eol !== d.eol) begin
                $error("end_of_line: expected %0b, got %0b", d.eol, eol);
                mismatches++;
            end
            if (last !== d.last) begin
                $error("last_of_run: expected %0b, got %0b", d.last, last);
                mismatches++;
            end
        endfunction

    endclass

endpackage

// File: verif/pcx_rle_line_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// PCX RLE line decoder unit testbench
// Directed bytes for literals, runs, clipping and register corner cases, then
// random streams under several line lengths and modes, with bursty input,
// patterned output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pcx_rle_line_decoder_unit_test;

    import pcxrle_pkg::*;
    import pcx_rle_line_decoder_unit_test_pkg::*;

    localparam int SETTLE_CYCLES = 8;     // beyond the last result before a register write
    localparam int LONG_HOLD     = 300;   // receiver hold-off for the fill-up phase
    localparam int IDLE_LIMIT    = 4000;  // cycles without any transfer before giving up
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped register index

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [LINE_W-1:0]    i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic [BYTE_W-1:0]    i_data_byte = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [BYTE_W-1:0]    o_pixel_byte;
    logic                 o_end_of_line;
    logic                 o_last_of_run;

    pcx_line_scoreboard sb;

    // sender burst state
    int unsigned burst_left = 0;
    bit          no_gaps    = 1'b0;

    // long hold-off request: main bumps the token, the receiver notices the change
    int unsigned hold_token = 0;
    int unsigned hold_seen  = 0;
    int unsigned hold_left  = 0;
    int unsigned pattern_left = 0;
    int unsigned stall_mode   = 0;

    int unsigned idle_cycles = 0;

    pcx_rle_line_decoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_byte  (o_pixel_byte),
        .o_end_of_line (o_end_of_line),
        .o_last_of_run (o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    // Both channels sampled in one process: an input transfer is always noted
    // before any output transfer of the same edge is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            sb.take_byte(i_data_byte);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_pixel(o_pixel_byte, o_end_of_line, o_last_of_run);
        end
    end

    // Receiver: stall pattern switches between randomly picked modes (no stall,
    // light, heavy, very heavy), overridden by the long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen   <= hold_token;
            hold_left   <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            if (pattern_left == 0) begin
                stall_mode   <= $urandom_range(0, 3);
                pattern_left <= $urandom_range(16, 80);
            end else begin
                pattern_left <= pattern_left - 1;
            end
            case (stall_mode)
                0: begin
                    i_out_stall <= 1'b0;
                end
                1: begin
                    i_out_stall <= ($urandom_range(0, 3) == 0);
                end
                2: begin
                    i_out_stall <= ($urandom_range(0, 1) == 0);
                end
                default: begin
                    i_out_stall <= ($urandom_range(0, 9) < 7);
                end
            endcase
        end
    end

    // Watchdog on cycles with no transfer of any kind
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall)
                || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // One register write; entered and left on a clock edge.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LINE_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        sb.set_reg(idx, value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // raw_mode write with junk in the unused upper bits
    task automatic write_raw_mode(logic raw);
        logic [LINE_W-1:0] value;
        value    = LINE_W'($urandom);
        value[0] = raw;
        write_reg(REG_RAW_MODE, value);
    endtask

    // One input transfer. A fresh burst may start with a gap; valid stays
    // high between transfers inside a burst.
    task automatic push_byte(logic [BYTE_W-1:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
    endtask

    // Drop valid and wait for every predicted byte, then let a run finish
    // off before anything touches the registers.
    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly header/value pairs and literals, some arbitrary bytes
    task automatic random_bytes(int unsigned count);
        int unsigned sent;
        int unsigned pick;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                push_byte(HEADER_MARK | BYTE_W'($urandom_range(0, 63)));
                push_byte(BYTE_W'($urandom_range(0, 255)));
                sent += 2;
            end else if (pick < 8) begin
                push_byte(BYTE_W'($urandom_range(0, 8'hBF)));
                sent++;
            end else begin
                push_byte(BYTE_W'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    task automatic run_phase(logic [LINE_W-1:0] len, logic raw, int unsigned count);
        write_reg(REG_LINE_LENGTH, len);
        write_raw_mode(raw);
        random_bytes(count);
        settle();
    endtask

    initial begin
        int unsigned k;
        sb = new();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed, reset settings: line of 80, run decoding ---
        // literals at the edges of the non-header range
        push_byte(8'h00);
        push_byte(8'hBF);
        push_byte(8'h3F);
        push_byte(8'h80);
        // header with count zero acts as one; value looks like a header
        push_byte(8'hC0);
        push_byte(8'hFF);
        // longest run
        push_byte(8'hFF);
        push_byte(8'hAA);
        push_byte(8'hC5);
        push_byte(8'hC7);
        // header left pending, then raw mode drops it and passes the byte
        push_byte(8'hE1);
        settle();
        write_raw_mode(1'b1);
        push_byte(8'hD3);
        settle();
        write_raw_mode(1'b0);
        // 63-byte run from position 74 is clipped to the line end
        push_byte(8'hFF);
        push_byte(8'h55);
        // line shortened below the current position: run clipped to one byte
        for (k = 1; k <= 5; k++) begin
            push_byte(BYTE_W'(k));
        end
        settle();
        write_reg(REG_LINE_LENGTH, 18'd3);
        push_byte(8'hCA);
        push_byte(8'h77);
        push_byte(8'h12);
        settle();
        // zero length behaves as one; unmapped index must leave it alone
        write_reg(REG_LINE_LENGTH, 18'd0);
        push_byte(8'h21);
        settle();
        write_reg(REG_SPARE, 18'h2AAAA);
        push_byte(8'hC3);
        push_byte(8'h44);
        push_byte(8'h3C);
        settle();

        // --- random streams under varied settings ---
        run_phase(18'd1, 1'b0, 12);
        run_phase(18'd0, 1'b0, 12);
        run_phase(18'd2, 1'b1, 12);
        run_phase(LINE_W'($urandom_range(3, 24)), 1'b0, 16);
        run_phase(18'd262140, 1'b0, 12);

        // fill-up: receiver holds off while the sender keeps offering
        write_reg(REG_LINE_LENGTH, 18'd50);
        write_raw_mode(1'b0);
        no_gaps = 1'b1;
        hold_token <= hold_token + 1;
        random_bytes(30);
        no_gaps = 1'b0;
        settle();

        run_phase(LINE_W'($urandom_range(80, 130)), 1'b0, 16);
        run_phase(18'd7, 1'b1, 8);
        run_phase(LINE_W'($urandom_range(1, 40)), 1'b0, 12);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: pcx_rle_line_decoder_unit.f
+incdir+src
src/pcxrle_pkg.sv
src/pcx_rle_line_decoder_unit.sv
src/pcxrle_checker.sv
verif/pcx_rle_line_decoder_unit_test_pkg.sv
verif/pcx_rle_line_decoder_unit_test.sv
